// ===== rtl/stk_pkg.sv =====
// package for the streaming top-k frequent block
package stk_pkg;
	localparam int NUM_VALUES = 256;
	localparam int MAX_K      = 16;
	localparam int COUNT_BITS = 16;
	localparam int VAL_W      = 8;
	localparam int RANK_W     = 4;
	localparam int K_W        = 5;
	localparam int ADDR_W     = $clog2(NUM_VALUES);
	localparam int SLOTS      = MAX_K + 1;
	localparam int SLOT_W     = $clog2(SLOTS);
	localparam logic [K_W-1:0] K_RESET = K_W'(4);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_FETCH, ST_READ, ST_BUBBLE, ST_EMIT
	} state_t;

	// one slot of the ranked list
	typedef struct packed {
		logic [VAL_W-1:0]      val;
		logic [COUNT_BITS-1:0] cnt;
	} slot_t;
endpackage

// ===== rtl/stk_if.sv =====
// valid/ready stream interfaces
interface stk_in_if;
	logic valid;
	logic ready;
	logic [7:0] value;
	logic new_stream;
	modport source (output valid, value, new_stream, input ready);
	modport sink (input valid, value, new_stream, output ready);
endinterface

interface stk_out_if;
	logic valid;
	logic ready;
	logic [7:0] entry;
	logic [3:0] rank;
	logic last;
	modport source (output valid, entry, rank, last, input ready);
	modport sink (input valid, entry, rank, last, output ready);
endinterface

interface stk_cfg_if;
	logic valid;
	logic ready;
	logic [4:0] top_count;
	modport source (output valid, top_count, input ready);
	modport sink (input valid, top_count, output ready);
endinterface

// ===== rtl/stk_ram.sv =====
// generic single port ram with registered read
module stk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ===== rtl/stk_cell.sv =====
// one list cell: holds a slot; clears, loads, or swaps with a neighbor on command
module stk_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clr,
	input  logic          load,
	input  stk_pkg::slot_t load_d,
	input  logic          take_up,
	input  logic          take_dn,
	input  stk_pkg::slot_t up_d,
	input  stk_pkg::slot_t dn_d,
	output stk_pkg::slot_t slot_q
);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (clr) begin
			slot_q <= '0;
		end else if (load) begin
			slot_q <= load_d;
		end else if (take_up) begin
			slot_q <= up_d;
		end else if (take_dn) begin
			slot_q <= dn_d;
		end
	end
endmodule

// ===== rtl/stream_top_k_frequent.sv =====
// top level of the streaming top-k frequent block
//
// channels: in carries value and new_stream, out carries entry, rank and
// last, cfg writes top_count (clamped to 1..16; a write restarts the stream)
// usage: one input word gives up to k output words, last marks the final one;
// a list with no filled slot gives no output word
// a chain of 17 list cells holds value and count per slot; the entry moves up
// one cell per cycle, deciding from the two neighbor registers
// counts live in a 256 x 16 ram with one port
// before the first output word the block reads the count, loads the entry
// and bubbles it up; then it gives one output word per cycle while out.ready
// is high; the block takes one item at a time (in.ready is high only in idle)
// reset, a cfg write and every new stream run a clearing pass over the whole
// count ram, during which in.ready is low; a new stream word then passes
// through ST_FETCH to re-read its count
// a stalled receiver holds the current output word; nothing is lost
module stream_top_k_frequent (
	input logic clk,
	input logic arst_n,
	stk_in_if.sink    in,
	stk_out_if.source out,
	stk_cfg_if.sink   cfg
);
	stk_pkg::state_t state_q, state_d;
	logic [stk_pkg::K_W-1:0]    topk_q;
	logic [stk_pkg::ADDR_W:0]   clr_q;
	logic [stk_pkg::VAL_W-1:0]  val_q;
	logic [stk_pkg::SLOT_W-1:0] pos_q;
	logic [stk_pkg::SLOT_W-1:0] idx_q;
	logic                       pend_new_q;

	// effective k, 1..MAX_K
	logic [stk_pkg::SLOT_W-1:0] k_eff;
	always_comb begin
		if (topk_q == '0) begin
			k_eff = stk_pkg::SLOT_W'(1);
		end else if (topk_q > stk_pkg::K_W'(stk_pkg::MAX_K)) begin
			k_eff = stk_pkg::SLOT_W'(stk_pkg::MAX_K);
		end else begin
			k_eff = stk_pkg::SLOT_W'(topk_q);
		end
	end

	// count ram
	logic                          ram_we;
	logic [stk_pkg::ADDR_W-1:0]    ram_addr;
	logic [stk_pkg::COUNT_BITS-1:0] ram_wdata, ram_rdata;
	stk_ram #(.WIDTH(stk_pkg::COUNT_BITS), .DEPTH(stk_pkg::NUM_VALUES)) u_cnt (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);
	logic [stk_pkg::COUNT_BITS-1:0] new_cnt;
	assign new_cnt = (ram_rdata == stk_pkg::COUNT_MAX) ? ram_rdata
		: ram_rdata + stk_pkg::COUNT_BITS'(1);

	// cell chain
	stk_pkg::slot_t slots [stk_pkg::SLOTS];
	logic [stk_pkg::SLOTS-1:0] c_load, c_up, c_dn;
	logic clr_list;
	stk_pkg::slot_t load_slot;

	// search: first matching slot below k, else k
	logic [stk_pkg::SLOT_W-1:0] hit_pos;
	always_comb begin
		hit_pos = k_eff;
		for (int i = stk_pkg::MAX_K - 1; i >= 0; i--) begin
			if (stk_pkg::SLOT_W'(i) < k_eff && slots[i].val == val_q) begin
				hit_pos = stk_pkg::SLOT_W'(i);
			end
		end
	end

	// compare the moving entry with its upper neighbor
	stk_pkg::slot_t me_s, up_s;
	logic pass;
	assign me_s = slots[pos_q];
	assign up_s = slots[pos_q - stk_pkg::SLOT_W'(1)];
	assign pass = (pos_q != '0) && ((me_s.cnt > up_s.cnt)
		|| (me_s.cnt == up_s.cnt && me_s.val < up_s.val));

	for (genvar g = 0; g < stk_pkg::SLOTS; g++) begin : g_cell
		stk_cell u_cell (
			.clk(clk), .arst_n(arst_n), .clr(clr_list),
			.load(c_load[g]), .load_d(load_slot),
			.take_up(c_up[g]), .take_dn(c_dn[g]),
			.up_d(slots[(g == 0) ? 0 : g - 1]),
			.dn_d(slots[(g == stk_pkg::SLOTS - 1) ? g : g + 1]),
			.slot_q(slots[g])
		);
	end

	logic out_last;
	assign out_last = (idx_q + stk_pkg::SLOT_W'(1) >= k_eff)
		|| (slots[idx_q + stk_pkg::SLOT_W'(1)].val == '0);

	// next state and datapath controls
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = val_q;
		ram_wdata = new_cnt;
		c_load    = '0;
		c_up      = '0;
		c_dn      = '0;
		clr_list  = 1'b0;
		load_slot = '{val: val_q, cnt: new_cnt};
		in.ready  = 1'b0;
		cfg.ready = (state_q == stk_pkg::ST_IDLE);
		out.valid = 1'b0;
		unique case (state_q)
			stk_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q[stk_pkg::ADDR_W-1:0];
				ram_wdata = '0;
				if (clr_q == (stk_pkg::ADDR_W+1)'(stk_pkg::NUM_VALUES - 1)) begin
					state_d = pend_new_q ? stk_pkg::ST_FETCH : stk_pkg::ST_IDLE;
				end
			end
			stk_pkg::ST_IDLE: begin
				in.ready = !cfg.valid;
				ram_addr = in.value;
				if (cfg.valid) begin
					clr_list = 1'b1;
					state_d  = stk_pkg::ST_CLEAR;
				end else if (in.valid) begin
					if (in.new_stream) begin
						clr_list = 1'b1;
						state_d  = stk_pkg::ST_CLEAR;
					end else begin
						state_d = stk_pkg::ST_READ;
					end
				end
			end
			stk_pkg::ST_FETCH: begin
				// read the cleared count of val_q
				state_d = stk_pkg::ST_READ;
			end
			stk_pkg::ST_READ: begin
				// ram_rdata holds the count of val_q
				if (val_q != '0) begin
					ram_we = 1'b1;
					c_load[hit_pos] = 1'b1;
					state_d = stk_pkg::ST_BUBBLE;
				end else begin
					state_d = (slots[0].val == '0) ? stk_pkg::ST_IDLE : stk_pkg::ST_EMIT;
				end
			end
			stk_pkg::ST_BUBBLE: begin
				if (pass) begin
					c_up[pos_q] = 1'b1;
					c_dn[pos_q - stk_pkg::SLOT_W'(1)] = 1'b1;
				end else begin
					state_d = stk_pkg::ST_EMIT;
				end
			end
			stk_pkg::ST_EMIT: begin
				out.valid = 1'b1;
				if (out.ready && out_last) begin
					state_d = stk_pkg::ST_IDLE;
				end
			end
			default: state_d = stk_pkg::ST_IDLE;
		endcase
	end

	assign out.entry = slots[idx_q].val;
	assign out.rank  = idx_q[stk_pkg::RANK_W-1:0];
	assign out.last  = out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stk_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			topk_q     <= stk_pkg::K_RESET;
			clr_q      <= '0;
			pend_new_q <= 1'b0;
			pos_q      <= '0;
			idx_q      <= '0;
			val_q      <= '0;
		end else begin
			if (state_q == stk_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == stk_pkg::ST_IDLE) begin
				clr_q <= '0;
				if (cfg.valid) begin
					topk_q     <= cfg.top_count;
					pend_new_q <= 1'b0;
				end else if (in.valid) begin
					val_q      <= in.value;
					pend_new_q <= in.new_stream;
				end
			end
			if (state_q == stk_pkg::ST_READ) begin
				// re-read address after a clear pass is val_q
				pos_q <= hit_pos;
				idx_q <= '0;
			end
			if (state_q == stk_pkg::ST_BUBBLE && pass) begin
				pos_q <= pos_q - stk_pkg::SLOT_W'(1);
			end
			if (state_q == stk_pkg::ST_EMIT && out.ready) begin
				idx_q <= idx_q + stk_pkg::SLOT_W'(1);
			end
		end
	end
endmodule

// ===== rtl/stk_checks.sv =====
// port-level checks for the top-k block, bound to the top level
module stk_checks (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_last,
	input logic [7:0] out_entry,
	input logic [3:0] out_rank
);
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_entry) && $stable(out_rank))
		else $error("output word changed under stall");
	a_no_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_entry != 8'd0)
		else $error("empty slot reported");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while reporting");
	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid && out_rank == $past(out_rank) + 4'd1)
		else $error("rank sequence broken");
endmodule

bind stream_top_k_frequent stk_checks u_stk_checks (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in.valid), .in_ready(in.ready),
	.out_valid(out.valid), .out_ready(out.ready), .out_last(out.last),
	.out_entry(out.entry), .out_rank(out.rank)
);

// ===== test/stk_checker.sv =====
// checker for the streaming top-k frequent block: predicts and compares output words
`timescale 1ns / 1ps

module stk_checker (
	input logic clk,
	input logic arst_n,
	stk_in_if   mon_in,
	stk_out_if  mon_out,
	stk_cfg_if  mon_cfg,
	output int  errors,
	output int  pending,
	output int  words_in,
	output int  words_out
);
	typedef struct {
		logic [stk_pkg::VAL_W-1:0]  entry;
		logic [stk_pkg::RANK_W-1:0] rank;
		logic                       last;
	} rank_word_t;

	logic [stk_pkg::COUNT_BITS-1:0] freq [stk_pkg::NUM_VALUES];
	logic [stk_pkg::VAL_W-1:0]      ranked [stk_pkg::SLOTS];
	logic [stk_pkg::K_W-1:0]        k_reg;
	rank_word_t                     ranking_q [$];

	function automatic void restart_stream();
		foreach (freq[i]) freq[i] = '0;
		foreach (ranked[i]) ranked[i] = '0;
	endfunction

	// one accepted input word: update counts and list, queue the reported ranking
	function automatic void rank_value(logic [stk_pkg::VAL_W-1:0] v, logic ns);
		int kk;
		int p;
		int n;
		logic [stk_pkg::VAL_W-1:0] up;
		logic [stk_pkg::VAL_W-1:0] me;
		rank_word_t w;
		kk = (k_reg == 0) ? 1 : (k_reg > stk_pkg::MAX_K) ? stk_pkg::MAX_K : int'(k_reg);
		if (ns) restart_stream();
		if (v != 0) begin
			if (freq[v] != stk_pkg::COUNT_MAX) freq[v] = freq[v] + 1'b1;
			ranked[kk] = v;
			p = kk;
			for (int i = 0; i < kk; i++) begin
				if (ranked[i] == v) begin
					p = i;
					break;
				end
			end
			while (p > 0) begin
				up = ranked[p-1];
				me = ranked[p];
				if (!(freq[me] > freq[up] || (freq[me] == freq[up] && me < up))) break;
				ranked[p-1] = me;
				ranked[p] = up;
				p--;
			end
		end
		n = 0;
		while (n < kk && ranked[n] != 0) n++;
		for (int i = 0; i < n; i++) begin
			w.entry = ranked[i];
			w.rank = stk_pkg::RANK_W'(i);
			w.last = (i == n - 1);
			ranking_q.push_back(w);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rank_word_t exp_w;
		if (!arst_n) begin
			restart_stream();
			k_reg = stk_pkg::K_RESET;
			ranking_q.delete();
		end else begin
			if (mon_cfg.valid && mon_cfg.ready) begin
				k_reg = mon_cfg.top_count;
				restart_stream();
			end
			if (mon_in.valid && mon_in.ready) begin
				words_in++;
				rank_value(mon_in.value, mon_in.new_stream);
			end
			if (mon_out.valid && mon_out.ready) begin
				words_out++;
				if (ranking_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected word entry=%0d rank=%0d last=%0d", $realtime,
						mon_out.entry, mon_out.rank, mon_out.last);
				end else begin
					exp_w = ranking_q.pop_front();
					if (mon_out.entry !== exp_w.entry || mon_out.rank !== exp_w.rank ||
						mon_out.last !== exp_w.last) begin
						errors++;
						$display("%0t: mismatch expected entry=%0d rank=%0d last=%0d, got %0d %0d %0d",
							$realtime, exp_w.entry, exp_w.rank, exp_w.last,
							mon_out.entry, mon_out.rank, mon_out.last);
					end
				end
			end
		end
		pending = ranking_q.size();
	end

	initial begin
		errors = 0;
		pending = 0;
		words_in = 0;
		words_out = 0;
	end
endmodule

// ===== test/stream_top_k_frequent_test.sv =====
// testbench top: stimulus, idling and verdict for the streaming top-k frequent block
`timescale 1ns / 1ps

module stream_top_k_frequent_test;
	// about 560 words, plus clearing passes
	localparam longint CYCLE_LIMIT = 500_000;
	// clearing pass plus the longest search, bubble and emit
	localparam int SETTLE = 320;
	localparam int HOLD_OFF = 400;
	localparam int FAST_RUN = 20;

	logic clk;
	logic arst_n;
	longint cycles;
	int errors, pending, words_in, words_out;
	int burst_left;
	int cfg_writes;
	bit fast;          // no idling on either side
	bit pressure_go;   // asks the receiver for its long hold-off
	bit pressure_done;

	stk_in_if  in_ch();
	stk_out_if out_ch();
	stk_cfg_if cfg_ch();

	stream_top_k_frequent u_top (
		.clk(clk), .arst_n(arst_n), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
	);

	stk_checker u_checker (
		.clk(clk), .arst_n(arst_n), .mon_in(in_ch), .mon_out(out_ch), .mon_cfg(cfg_ch),
		.errors(errors), .pending(pending), .words_in(words_in), .words_out(words_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: stalls follow a random mode per window; one long hold-off on request
	initial begin
		int mode;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (pressure_go && !pressure_done) begin
				@(negedge clk);
				out_ch.ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
				pressure_done = 1'b1;
			end else begin
				mode = $urandom_range(0, 3);
				repeat ($urandom_range(8, 64)) begin
					@(negedge clk);
					if (fast || mode == 0) out_ch.ready <= 1'b1;
					else if (mode == 1) out_ch.ready <= ($urandom_range(0, 1) == 1);
					else if (mode == 2) out_ch.ready <= ($urandom_range(0, 3) == 0);
					else out_ch.ready <= ($urandom_range(0, 7) != 0);
				end
			end
		end
	end

	// offer one input word and hold it until taken; outside fast mode bursts end in a random gap
	task automatic put_word(input logic [7:0] v, input logic ns);
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.value <= v;
		in_ch.new_stream <= ns;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			if (!fast) begin
				@(negedge clk);
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(0, 15)) @(negedge clk);
			end
		end
	endtask

	// stop offering and let every expected word come out, plus settle time
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (pending == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// k register write, only with the block idle
	task automatic write_k(input logic [4:0] k);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.top_count <= k;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cfg_writes++;
	endtask

	// mostly a small pool so values repeat and climb; sometimes anything
	function automatic logic [7:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3) return 8'd0;
		if (r < 75) return 8'($urandom_range(1, 24));
		return 8'($urandom_range(1, 255));
	endfunction

	initial begin
		logic [4:0] k_plan [5];
		cycles = 0;
		fast = 1'b0;
		pressure_go = 1'b0;
		pressure_done = 1'b0;
		burst_left = 5;
		cfg_writes = 0;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		in_ch.new_stream = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.top_count = '0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset k, empty list, zero value, extremes, ties, restart
		put_word(8'd0, 1'b0);    // empty list: nothing reported
		put_word(8'd255, 1'b0);
		put_word(8'd1, 1'b0);    // tie with 255, smaller value wins
		put_word(8'd255, 1'b0);
		put_word(8'd0, 1'b0);    // zero still reports the list
		put_word(8'd7, 1'b0);
		put_word(8'd9, 1'b0);
		put_word(8'd8, 1'b0);    // fifth value falls in the spare slot
		put_word(8'd8, 1'b0);
		put_word(8'd8, 1'b0);
		put_word(8'd9, 1'b0);
		put_word(8'd0, 1'b1);    // restart with zero: empty again
		put_word(8'd170, 1'b1);
		put_word(8'd85, 1'b0);
		write_k(5'd0);           // clamps to one
		put_word(8'd3, 1'b0);
		put_word(8'd2, 1'b0);
		put_word(8'd2, 1'b0);
		write_k(5'd31);          // clamps to sixteen
		for (int i = 1; i <= 18; i++) put_word(8'(i * 13), 1'b0);
		put_word(8'd0, 1'b0);

		// random phases over several k settings
		k_plan[0] = 5'd16;
		k_plan[1] = 5'($urandom_range(17, 31));
		k_plan[2] = 5'd1;
		k_plan[3] = 5'($urandom_range(0, 31));
		k_plan[4] = 5'($urandom_range(2, 15));
		foreach (k_plan[p]) begin
			write_k(k_plan[p]);
			for (int i = 0; i < 100; i++) begin
				if (p == 0 && i == 30) pressure_go = 1'b1;
				put_word(pick_value(), $urandom_range(0, 99) < 3);
			end
		end

		// back to back words with no idling on either side
		write_k(5'd2);
		fast = 1'b1;
		for (int i = 0; i < FAST_RUN; i++) put_word(pick_value(), 1'b0);
		fast = 1'b0;
		put_word(8'd4, 1'b0);

		drain();
		$display("run covered %0d input words and %0d output words over %0d k writes,",
			words_in, words_out, cfg_writes);
		$display("including a long receiver hold-off and a stretch with no idling");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
